// ===== hdl/utc_pkg.sv =====
// shared types and character constants for the utc time string parser
// no dependencies
package utc_pkg;

  localparam logic [7:0] CharZero = 8'h30;  // '0'
  localparam logic [7:0] CharNine = 8'h39;  // '9'
  localparam logic [7:0] CharZulu = 8'h5A;  // 'Z'

  localparam logic [3:0] PosSecHi   = 4'd10;  // first seconds byte
  localparam logic [3:0] PosFull    = 4'd12;  // position counter saturates here
  localparam logic [6:0] YearPivot  = 7'd50;
  localparam logic [11:0] YearBase  = 12'd1900;
  localparam logic [11:0] CenturyUp = 12'd100;
  localparam logic [6:0] MonthMax   = 7'd12;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] year;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        utc_zone;
  } out_item_t;

  // handshake between the parse stage and the result register
  typedef struct packed {
    logic done;     // parse stage holds the last byte of a string
    logic advance;  // parse stage item moves on this cycle
  } stage_ctl_t;

  // acc * 10 + d, kept to seven bits
  function automatic logic [6:0] acc_digit(input logic [6:0] acc, input logic [3:0] d);
    logic [10:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
    return sum[6:0];
  endfunction

endpackage

// ===== hdl/utc_in_stage.sv =====
// input register of the utc time string parser
// depends on utc_pkg
module utc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  utc_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output utc_pkg::in_item_t item_o
);
  import utc_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== hdl/utc_field_acc.sv =====
// field accumulators, position counter and result formatting
// depends on utc_pkg
module utc_field_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  utc_pkg::in_item_t   item_i,
  input  logic                advance_i,
  output logic                done_o,
  output utc_pkg::out_item_t  result_o
);
  import utc_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic [6:0] year_q, year_d, month_q, month_d, day_q, day_d;
  logic [6:0] hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic       bad_q, bad_d, secnum_q, secnum_d;

  logic       is_digit;
  logic [3:0] dig;
  logic       ok;
  logic [11:0] year_full;

  assign is_digit = (item_i.char_byte >= CharZero) && (item_i.char_byte <= CharNine);
  assign dig      = is_digit ? item_i.char_byte[3:0] : 4'd0;
  assign done_o   = valid_i & item_i.last_byte;

  // next accumulator values with this byte folded in
  always_comb begin
    pos_d    = pos_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    bad_d    = bad_q;
    secnum_d = secnum_q;
    if (pos_q < PosSecHi) begin
      if (!is_digit) bad_d = 1'b1;
      case (pos_q[3:1])
        3'd0:    year_d   = acc_digit(year_q, dig);
        3'd1:    month_d  = acc_digit(month_q, dig);
        3'd2:    day_d    = acc_digit(day_q, dig);
        3'd3:    hour_d   = acc_digit(hour_q, dig);
        default: minute_d = acc_digit(minute_q, dig);
      endcase
    end else if (pos_q < PosFull) begin
      if (!is_digit) secnum_d = 1'b0;
      second_d = acc_digit(second_q, dig);
    end
    if (pos_q < PosFull) pos_d = pos_q + 4'd1;
  end

  assign ok = (pos_d >= PosSecHi) && !bad_d && (month_d != 7'd0) && (month_d <= MonthMax);
  assign year_full = YearBase + {5'd0, year_d} + ((year_d < YearPivot) ? CenturyUp : 12'd0);

  always_comb begin
    result_o = '0;
    if (ok) begin
      result_o.valid_res = 1'b1;
      result_o.year      = year_full;
      result_o.month     = month_d[3:0];
      result_o.day       = day_d;
      result_o.hour      = hour_d;
      result_o.minute    = minute_d;
      result_o.second    = ((pos_d == PosFull) && secnum_d) ? second_d : 7'd0;
      result_o.utc_zone  = (item_i.char_byte == CharZulu);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      bad_q    <= 1'b0;
      secnum_q <= 1'b1;
    end else if (valid_i && advance_i) begin
      if (item_i.last_byte) begin
        pos_q    <= '0;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
        bad_q    <= 1'b0;
        secnum_q <= 1'b1;
      end else begin
        pos_q    <= pos_d;
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
        bad_q    <= bad_d;
        secnum_q <= secnum_d;
      end
    end
  end
endmodule

// ===== hdl/utc_out_stage.sv =====
// result register with valid/stall handshake
// depends on utc_pkg
module utc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utc_pkg::stage_ctl_t ctl_i,
  input  utc_pkg::out_item_t  result_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output utc_pkg::out_item_t  out_item_o
);
  import utc_pkg::*;

  logic      valid_q, valid_d, load;
  out_item_t item_q;

  assign room_o = ~valid_q | ~out_stall_i;
  assign load   = ctl_i.done & ctl_i.advance;

  always_comb begin
    if (load) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
endmodule

// ===== hdl/utc_time_string_parser_unit.sv =====
// top level of the utc time string parser: input register, parse stage, result register
// depends on utc_pkg, utc_in_stage, utc_field_acc, utc_out_stage
//
// usage
// - input channel: in_valid_i / in_stall_o carry one character byte per item,
//   with last_byte set on the final character of a time string
// - output channel: out_valid_o / out_stall_i carry one parsed result per string,
//   produced only for the item that has last_byte set
// - result path: the last byte waits in the input register until the result register
//   has room, then the result register loads the parsed result and offers it
// - throughput: one byte per cycle unless a last byte waits on a full, stalled result
//   register; the accumulators update in the cycle the byte leaves the input register
// - a new byte is taken while a finished result still waits in the result register;
//   only a last byte waits on a full, stalled result register
// - stall: out_stall_i holds the result; in_stall_o rises when a last byte is
//   held back, bytes that are not last keep flowing
// - reset: empties both registers and returns all accumulators to the start of a
//   string (seconds marked numeric, position zero)
module utc_time_string_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  utc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utc_pkg::out_item_t out_item_o
);
  import utc_pkg::*;

  logic       stg_valid;
  in_item_t   stg_item;
  logic       room;
  logic       done;
  out_item_t  result;
  stage_ctl_t ctl;

  // a byte that ends a string needs room in the result register
  assign ctl.done    = done;
  assign ctl.advance = stg_valid & (~stg_item.last_byte | room);

  utc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (ctl.advance),
    .valid_o    (stg_valid),
    .item_o     (stg_item)
  );

  // digit accumulation and result formatting
  utc_field_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stg_valid),
    .item_i    (stg_item),
    .advance_i (ctl.advance),
    .done_o    (done),
    .result_o  (result)
  );

  utc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .result_i    (result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );
endmodule

// ===== hdl/utc_checker.sv =====
// port-level checks for the utc time string parser
// depends on utc_pkg and utc_time_string_parser_unit
module utc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input utc_pkg::out_item_t out_item_o
);
  import utc_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

  // a failed parse carries all-zero fields
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.valid_res |-> out_item_o == '0)
    else $error("invalid result has nonzero fields");

  // a good parse has a windowed year and a checked month
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.valid_res |->
      out_item_o.year >= 12'd1950 && out_item_o.year <= 12'd2049 &&
      out_item_o.month >= 4'd1 && out_item_o.month <= 4'd12)
    else $error("year or month out of range");

  // two-digit fields never exceed 99
  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.day <= 7'd99 && out_item_o.hour <= 7'd99 &&
      out_item_o.minute <= 7'd99 && out_item_o.second <= 7'd99)
    else $error("two-digit field above 99");
endmodule

bind utc_time_string_parser_unit utc_checker u_utc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== verif/utc_result_checker.sv =====
// checker for the utc time string parser: predicts each parsed time from the accepted
// character items and compares it with the result channel; depends on utc_pkg
module utc_result_checker
  import utc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned ReportMax = 10;

  // parse state of the string in flight
  logic [3:0] char_pos;
  logic [6:0] yy_sum, mon_sum, day_sum, hr_sum, min_sum, sec_sum;
  logic       saw_non_digit;
  logic       sec_digits_ok;

  out_item_t   predicted_time_q[$];
  int unsigned fail_total = 0;
  int unsigned pending_n = 0;

  assign fail_count_o = fail_total;
  assign pending_o    = pending_n;

  function automatic logic [6:0] shift_in_digit(input logic [6:0] sum, input logic [3:0] dv);
    int unsigned t;
    t = int'(sum) * 10 + int'(dv);
    return t[6:0];
  endfunction

  function automatic string time_text(input out_item_t r);
    return $sformatf("ok=%0d year=%0d month=%0d day=%0d hour=%0d min=%0d sec=%0d zulu=%0d",
                     r.valid_res, r.year, r.month, r.day, r.hour, r.minute, r.second,
                     r.utc_zone);
  endfunction

  task automatic clear_parse();
    char_pos      = '0;
    yy_sum        = '0;
    mon_sum       = '0;
    day_sum       = '0;
    hr_sum        = '0;
    min_sum       = '0;
    sec_sum       = '0;
    saw_non_digit = 1'b0;
    sec_digits_ok = 1'b1;
  endtask

  task automatic parse_char(input in_item_t it);
    logic       is_dig;
    logic [3:0] dv;
    int unsigned full_year;
    out_item_t  r;
    is_dig = (it.char_byte >= CharZero) && (it.char_byte <= CharNine);
    dv     = is_dig ? 4'(it.char_byte - CharZero) : 4'd0;
    if (char_pos < PosSecHi) begin
      if (!is_dig) saw_non_digit = 1'b1;
      case (char_pos[3:1])
        3'd0: yy_sum = shift_in_digit(yy_sum, dv);
        3'd1: mon_sum = shift_in_digit(mon_sum, dv);
        3'd2: day_sum = shift_in_digit(day_sum, dv);
        3'd3: hr_sum = shift_in_digit(hr_sum, dv);
        default: min_sum = shift_in_digit(min_sum, dv);
      endcase
    end else if (char_pos < PosFull) begin
      if (!is_dig) sec_digits_ok = 1'b0;
      sec_sum = shift_in_digit(sec_sum, dv);
    end
    if (char_pos < PosFull) char_pos = char_pos + 4'd1;
    if (it.last_byte) begin
      r = '0;
      if (char_pos >= PosSecHi && !saw_non_digit && mon_sum >= 7'd1 && mon_sum <= MonthMax)
      begin
        full_year = int'(yy_sum) + int'(YearBase);
        if (yy_sum < YearPivot) full_year = full_year + int'(CenturyUp);
        r.valid_res = 1'b1;
        r.year      = full_year[11:0];
        r.month     = mon_sum[3:0];
        r.day       = day_sum;
        r.hour      = hr_sum;
        r.minute    = min_sum;
        r.second    = (char_pos >= PosFull && sec_digits_ok) ? sec_sum : 7'd0;
        r.utc_zone  = (it.char_byte == CharZulu);
      end
      predicted_time_q.push_back(r);
      clear_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_parse();
      predicted_time_q.delete();
    end else begin
      // result side first: a result never leaves in the cycle its last byte enters
      if (out_valid_i && !out_stall_i) begin
        if (predicted_time_q.size() == 0) begin
          fail_total++;
          if (fail_total <= ReportMax)
            $display("unexpected result: %s", time_text(out_item_i));
        end else begin
          want = predicted_time_q.pop_front();
          if (out_item_i.valid_res !== want.valid_res || out_item_i.year !== want.year ||
              out_item_i.month !== want.month || out_item_i.day !== want.day ||
              out_item_i.hour !== want.hour || out_item_i.minute !== want.minute ||
              out_item_i.second !== want.second || out_item_i.utc_zone !== want.utc_zone)
          begin
            fail_total++;
            if (fail_total <= ReportMax)
              $display("result mismatch\n  expected: %s\n  actual:   %s",
                       time_text(want), time_text(out_item_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(in_item_i);
    end
    pending_n = predicted_time_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the utc time string parser: drives character items and result stall,
// gives the verdict; depends on utc_pkg, utc_result_checker and the parser unit
module tb_top;
  import utc_pkg::*;

  localparam int unsigned ItemTarget    = 1450;  // random part stops near this many items
  localparam int unsigned QuietTail     = 150;   // last items run without idling
  localparam int unsigned WatchdogLimit = 3000;  // cycles with no item moving on either side
  localparam int unsigned HoldCycle     = 600;   // when the long receiver hold starts
  localparam int unsigned HoldLength    = 300;   // length of that hold in cycles
  localparam int unsigned DrainCycles   = 8;     // extra cycles waited after the last expected result

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  int unsigned fail_count;
  int unsigned pending;

  // stimulus bookkeeping of the sender; quiet_tail is shared with the receiver
  logic [7:0]  text_q[$];
  int unsigned items_sent = 0;
  bit          quiet_tail = 1'b0;
  bit          sender_calm = 1'b0;

  utc_time_string_parser_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  utc_result_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // free-running clock, period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // character helpers for building time strings
  task automatic add_pair(input int unsigned v);
    text_q.push_back(CharZero + 8'(v / 10));
    text_q.push_back(CharZero + 8'(v % 10));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // one character item; called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && !sender_calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    // hold the item until the parser takes it
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // send text_q as one string, last flag on its final byte, then empty it
  task automatic send_text();
    in_item_t it;
    for (int i = 0; i < text_q.size(); i++) begin
      it.char_byte = text_q[i];
      it.last_byte = (i == text_q.size() - 1);
      send_byte(it);
    end
    text_q.delete();
  endtask

  // mostly well-formed strings with random content, the rest broken or noise
  task automatic build_random_text();
    int unsigned kind;
    int unsigned tail;
    int unsigned n;
    kind = $urandom_range(0, 99);
    text_q.delete();
    if (kind < 8) begin
      // short string, mostly digits
      n = $urandom_range(1, 9);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
        else text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
      end
    end else if (kind < 14) begin
      // raw noise of one to sixteen bytes
      n = $urandom_range(1, 16);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_pair($urandom_range(0, 99));
      // out-of-range month now and then, month zero included
      if (kind < 24) add_pair(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(13, 99));
      else add_pair($urandom_range(1, 12));
      add_pair($urandom_range(0, 99));
      add_pair($urandom_range(0, 99));
      add_pair($urandom_range(0, 99));
      // spoil one field byte
      if (kind >= 24 && kind < 32) text_q[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
      tail = $urandom_range(0, 6);
      case (tail)
        0: ;
        1: text_q.push_back(CharZulu);
        2: text_q.push_back(CharZero + 8'($urandom_range(0, 9)));
        3: add_pair($urandom_range(0, 99));
        4: begin
          add_pair($urandom_range(0, 99));
          text_q.push_back(CharZulu);
        end
        5: begin
          // non-numeric seconds, sometimes with a longer tail
          add_pair($urandom_range(0, 99));
          text_q[10 + $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
          repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 0) text_q.push_back(CharZulu);
        end
        default: begin
          // long string: seconds then extra bytes, ending in a random byte or zulu
          add_pair($urandom_range(0, 99));
          repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 0) text_q.push_back(CharZulu);
        end
      endcase
    end
  endtask

  // sender: reset, directed strings, random strings, drain and verdict
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single all-ones byte: too short
    text_q.push_back(8'hFF);
    send_text();
    // lowest windowed year, ten bytes exactly, no seconds, last byte not zulu
    add_text("5001319999");
    send_text();
    // highest windowed year, top month, long string with seconds and zulu
    add_text("491200000059Z");
    send_text();

    while (items_sent < ItemTarget) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      if (items_sent + QuietTail >= ItemTarget) quiet_tail = 1'b1;
      build_random_text();
      send_text();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("utc_time_string_parser_unit regression: pass");
    end else begin
      $display("utc_time_string_parser_unit regression: fail");
    end
    $finish;
  end

  // receiver: random stall bursts, calm stretches, one long hold to back up the parser
  initial begin
    int unsigned cyc;
    int unsigned stall_left;
    bit          calm;
    out_stall  = 1'b0;
    cyc        = 0;
    stall_left = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (cyc == HoldCycle) stall_left = HoldLength;
      else if (stall_left == 0 && !calm && !quiet_tail && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 14);
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // watchdog on cycles where no item moves on either channel
  initial begin
    int unsigned still;
    still = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) still = 0;
      else still++;
      if (still >= WatchdogLimit) begin
        $display("utc_time_string_parser_unit regression: fail");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/utc_pkg.sv
hdl/utc_in_stage.sv
hdl/utc_field_acc.sv
hdl/utc_out_stage.sv
hdl/utc_time_string_parser_unit.sv
hdl/utc_checker.sv
verif/utc_result_checker.sv
verif/tb_top.sv
